[hdl/hcx_pkg.sv]
// Shared types, constants and the ALU function of the execute core.
package hcx_pkg;

    localparam int RAM_WORDS = 16384;
    localparam int RAM_AW    = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
    localparam logic [RAM_AW-1:0] RAM_LAST   = RAM_AW'(RAM_WORDS - 1);
    localparam logic [16:0]       RAM_LIMIT  = 17'(RAM_WORDS);

    // Bit positions in comp_sel, dest and jump.
    localparam int COMP_MEM = 6;
    localparam int DEST_A   = 2;
    localparam int DEST_D   = 1;
    localparam int DEST_M   = 0;
    localparam int JUMP_NEG = 2;
    localparam int JUMP_ZER = 1;
    localparam int JUMP_POS = 0;

    // ALU control bits within comp_sel[5:0].
    localparam int ALU_ZX = 5;
    localparam int ALU_NX = 4;
    localparam int ALU_ZY = 3;
    localparam int ALU_NY = 2;
    localparam int ALU_F  = 1;
    localparam int ALU_NO = 0;

    localparam logic FUNC_LOAD = 1'b0;

    typedef struct packed {
        logic        func;
        logic [14:0] const_value;
        logic [6:0]  comp_sel;
        logic [2:0]  dest;
        logic [2:0]  jump;
    } t_req;

    typedef struct packed {
        logic [14:0]        next_pc;
        logic signed [15:0] a_value;
        logic signed [15:0] d_value;
        logic signed [15:0] alu_out;
        logic               mem_written;
    } t_res;

    // Classified instruction as it travels through the queue.
    typedef struct packed {
        logic        is_calc;
        logic [14:0] const_value;
        logic        use_mem;
        logic [5:0]  alu_ctl;
        logic        wr_a;
        logic        wr_d;
        logic        wr_m;
        logic [2:0]  jump;
    } t_op;

    function automatic logic [15:0] alu_eval(input logic [15:0] x_in,
                                             input logic [15:0] y_in,
                                             input logic [5:0]  ctl);
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] r;
        x = ctl[ALU_ZX] ? 16'h0000 : x_in;
        x = ctl[ALU_NX] ? ~x : x;
        y = ctl[ALU_ZY] ? 16'h0000 : y_in;
        y = ctl[ALU_NY] ? ~y : y;
        r = ctl[ALU_F] ? (x + y) : (x & y);
        r = ctl[ALU_NO] ? ~r : r;
        return r;
    endfunction

endpackage

[hdl/hcx_ram.sv]
// Generic single-write, single-read RAM with registered (read-first) output.
module hcx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/hcx_front.sv]
// Front end: takes requests and classifies them into queue entries.
module hcx_front (
    input  logic          i_valid,
    input  hcx_pkg::t_req i_req,
    input  logic          i_q_full,
    input  logic          i_clr_busy,
    output logic          o_ready,
    output logic          o_push,
    output hcx_pkg::t_op  o_op
);
    import hcx_pkg::*;

    logic is_calc;

    assign o_ready = !i_q_full && !i_clr_busy;
    assign o_push  = i_valid && o_ready;
    assign is_calc = (i_req.func != FUNC_LOAD);

    // Load-constant requests drop every compute side effect here.
    always_comb begin
        o_op.is_calc     = is_calc;
        o_op.const_value = i_req.const_value;
        o_op.use_mem     = is_calc && i_req.comp_sel[COMP_MEM];
        o_op.alu_ctl     = i_req.comp_sel[5:0];
        o_op.wr_a        = is_calc && i_req.dest[DEST_A];
        o_op.wr_d        = is_calc && i_req.dest[DEST_D];
        o_op.wr_m        = is_calc && i_req.dest[DEST_M];
        o_op.jump        = is_calc ? i_req.jump : 3'b000;
    end

endmodule

[hdl/hcx_queue.sv]
// Two-entry queue between the front end and the execute back end.
module hcx_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  hcx_pkg::t_op i_op,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output hcx_pkg::t_op o_op
);
    import hcx_pkg::*;

    t_op        r_entry [2];
    logic       r_head, n_head;
    logic       r_tail, n_tail;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_entry[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = ~r_tail;
        end
        if (i_pop) begin
            n_head = ~r_head;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
        if (i_push) begin
            r_entry[r_tail] <= i_op;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

[hdl/hcx_back.sv]
// Back end: register file, data memory, ALU, jump logic and result register.
module hcx_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  hcx_pkg::t_op  i_op,
    output logic          o_pop,
    output logic          o_clr_busy,
    output logic          o_valid,
    input  logic          i_ready,
    output hcx_pkg::t_res o_res
);
    import hcx_pkg::*;

    logic [15:0]       r_a, n_a;
    logic [15:0]       r_d, n_d;
    logic [14:0]       r_pc, n_pc;
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_addr;
    logic              r_out_valid;
    t_res              r_out;
    logic              r_byp;
    logic [15:0]       r_byp_data;

    logic              exec;
    logic              in_range;
    logic [15:0]       ram_q;
    logic [15:0]       mval;
    logic [15:0]       y_in;
    logic [15:0]       res;
    logic              neg;
    logic              zero;
    logic              taken;
    logic              mem_we;
    logic [RAM_AW-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [RAM_AW-1:0] mem_raddr;

    assign exec       = i_q_valid && (!r_out_valid || i_ready) && !r_clr_busy;
    assign o_pop      = exec;
    assign o_clr_busy = r_clr_busy;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    assign in_range = ({1'b0, r_a} < RAM_LIMIT);
    // RAM output is the word at A, read last cycle; bypass and out-of-range zero apply.
    assign mval  = !in_range ? 16'h0000 : (r_byp ? r_byp_data : ram_q);
    assign y_in  = i_op.use_mem ? mval : r_a;
    assign res   = alu_eval(r_d, y_in, i_op.alu_ctl);
    assign neg   = res[15];
    assign zero  = (res == 16'h0000);
    assign taken = (i_op.jump[JUMP_NEG] && neg) || (i_op.jump[JUMP_ZER] && zero) ||
                   (i_op.jump[JUMP_POS] && !neg && !zero);

    always_comb begin
        n_a  = r_a;
        n_d  = r_d;
        n_pc = r_pc;
        if (exec) begin
            if (!i_op.is_calc) begin
                n_a = {1'b0, i_op.const_value};
            end else if (i_op.wr_a) begin
                n_a = res;
            end
            if (i_op.wr_d) begin
                n_d = res;
            end
            n_pc = taken ? r_a[14:0] : (r_pc + 15'd1);
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = 16'h0000;
        end else begin
            mem_we    = exec && i_op.wr_m && in_range;
            mem_waddr = r_a[RAM_AW-1:0];
            mem_wdata = res;
        end
    end

    // Read ahead at the A value the next instruction will see.
    assign mem_raddr = n_a[RAM_AW-1:0];

    hcx_ram #(
        .WIDTH(16),
        .DEPTH(RAM_WORDS)
    ) u_data_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= 16'h0000;
            r_d         <= 16'h0000;
            r_pc        <= 15'd0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_a  <= n_a;
            r_d  <= n_d;
            r_pc <= n_pc;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + RAM_AW'(1);
                if (r_clr_addr == RAM_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_byp <= mem_we && (mem_waddr == mem_raddr);
        end
        r_byp_data <= mem_wdata;
        if (exec) begin
            r_out.next_pc     <= n_pc;
            r_out.a_value     <= n_a;
            r_out.d_value     <= n_d;
            r_out.alu_out     <= i_op.is_calc ? res : 16'h0000;
            r_out.mem_written <= mem_we;
        end
    end

    a_no_exec_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && exec))
        else $error("instruction executed during memory clear");
    a_write_needs_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && !r_clr_busy) |-> (exec && i_op.wr_m && in_range))
        else $error("stray data memory write");
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> (r_out_valid && r_out.next_pc == r_pc))
        else $error("executed instruction produced no result");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result overwritten");

endmodule

[hdl/hack_cpu_execute_core.sv]
// Top level of the 16-bit two-register execute core.
//
// Usage:
//   Input channel (i_valid / o_ready / i_req) carries one instruction per
//   request: load-constant (func 0) or compute (func 1). Output channel
//   (o_valid / i_ready / o_res) returns one result request per instruction:
//   next PC, A, D, ALU result and the memory-write flag, in program order.
//   An accepted request is registered in the queue, then executed into the
//   result register. Throughput: one instruction per clock while i_ready is
//   high. The data memory is read ahead at the A value the next instruction
//   will see, with a write bypass, so a memory operand never stalls the pipe.
//   Reset (i_rst_n low, synchronous): A, D and PC go to zero and the queue
//   empties. Afterwards a clearing pass writes zero into all RAM_WORDS data
//   words, one word a cycle (16384 words by default); o_ready stays low
//   until it ends.
//   Receiver stall: the result register holds its request; the back end
//   stops and the two-entry queue fills, after which o_ready drops.
module hack_cpu_execute_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hcx_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output hcx_pkg::t_res o_res
);
    import hcx_pkg::*;

    t_op  push_op;
    t_op  head_op;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    logic clr_busy;

    // Classify and accept requests.
    hcx_front u_front (
        .i_valid   (i_valid),
        .i_req     (i_req),
        .i_q_full  (q_full),
        .i_clr_busy(clr_busy),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_op      (push_op)
    );

    // Decouple acceptance from execution.
    hcx_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (push_op),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_op   (head_op)
    );

    // Execute, update state and hold the result for the receiver.
    hcx_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .o_pop     (pop),
        .o_clr_busy(clr_busy),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (o_res)
    );

endmodule
